// ----- rtl/tcce_pkg.sv -----
// tcce_pkg: screen geometry, character codes, request and command codes,
// and the command/status structs shared by the console engine modules.
// No dependencies.
package tcce_pkg;

  localparam int COLS       = 80;
  localparam int ROWS       = 25;
  localparam int CELLS      = COLS * ROWS;
  localparam int COPY_CELLS = CELLS - COLS;
  localparam int LINE_MAX   = 256;

  localparam int CELL_W = 11;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int LINE_W = $clog2(LINE_MAX);
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int DATA_W = ATTR_W + CHAR_W;
  localparam int REQ_W  = 3;
  localparam int LIDX_W = 8;
  localparam int CNT_W  = $clog2(CELLS + 1);

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd7;
  localparam logic [DATA_W-1:0] RESET_CELL   = {ATTR_RESET, CH_SPACE};

  // configuration register index (paddr word select)
  localparam logic REG_ATTR = 1'b0;

  typedef enum logic [REQ_W-1:0] {
    REQ_OUT       = 3'd0,
    REQ_KEY       = 3'd1,
    REQ_CLEAR     = 3'd2,
    REQ_READ_CELL = 3'd3,
    REQ_READ_LINE = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_FILL,
    S_SCROLL,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_OUT,
    OP_KEY,
    OP_READ,
    OP_CLEAR,
    OP_FILL,
    OP_INIT_FILL,
    OP_SCROLL
  } op_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_CELL,
    RD_LINE
  } rd_sel_t;

  typedef struct packed {
    op_t  op;
    logic load;
    logic result;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic scroll_need;
    logic fill_last;
    logic copy_last;
    logic out_busy;
  } stat_t;

  function automatic logic [CELL_W-1:0] pos_of(input logic [ROW_W-1:0] row,
                                               input logic [COL_W-1:0] col);
    pos_of = CELL_W'(row) * CELL_W'(COLS) + CELL_W'(col);
  endfunction

endpackage

// ----- rtl/tcce_ctrl.sv -----
// tcce_ctrl: request sequencer for the console engine.
// Drives tcce_datapath through tcce_pkg::cmd_t, reads tcce_pkg::stat_t.
module tcce_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  tcce_pkg::stat_t stat,
  output tcce_pkg::cmd_t  cmd
);

  tcce_pkg::state_t state_r;
  tcce_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcce_pkg::S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcce_pkg::S_INIT: begin
        if (stat.fill_last) state_nxt = tcce_pkg::S_IDLE;
      end
      tcce_pkg::S_IDLE: begin
        if (in_valid) state_nxt = tcce_pkg::S_EXEC;
      end
      tcce_pkg::S_EXEC: begin
        if (stat.req == tcce_pkg::REQ_CLEAR) begin
          state_nxt = tcce_pkg::S_FILL;
        end else if (stat.scroll_need) begin
          state_nxt = tcce_pkg::S_SCROLL;
        end else begin
          state_nxt = tcce_pkg::S_DONE;
        end
      end
      tcce_pkg::S_FILL: begin
        if (stat.fill_last) state_nxt = tcce_pkg::S_DONE;
      end
      tcce_pkg::S_SCROLL: begin
        if (stat.copy_last) state_nxt = tcce_pkg::S_DONE;
      end
      tcce_pkg::S_DONE: begin
        if (!stat.out_busy) begin
          state_nxt = in_valid ? tcce_pkg::S_EXEC : tcce_pkg::S_IDLE;
        end
      end
      default: state_nxt = tcce_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op     = tcce_pkg::OP_NONE;
    cmd.load   = 1'b0;
    cmd.result = 1'b0;
    in_stall   = 1'b1;
    unique case (state_r)
      tcce_pkg::S_INIT: cmd.op = tcce_pkg::OP_INIT_FILL;
      tcce_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      tcce_pkg::S_EXEC: begin
        unique case (stat.req)
          tcce_pkg::REQ_OUT:       cmd.op = tcce_pkg::OP_OUT;
          tcce_pkg::REQ_KEY:       cmd.op = tcce_pkg::OP_KEY;
          tcce_pkg::REQ_CLEAR:     cmd.op = tcce_pkg::OP_CLEAR;
          tcce_pkg::REQ_READ_CELL: cmd.op = tcce_pkg::OP_READ;
          tcce_pkg::REQ_READ_LINE: cmd.op = tcce_pkg::OP_READ;
          default:                 cmd.op = tcce_pkg::OP_NONE;
        endcase
      end
      tcce_pkg::S_FILL:   cmd.op = tcce_pkg::OP_FILL;
      tcce_pkg::S_SCROLL: cmd.op = tcce_pkg::OP_SCROLL;
      tcce_pkg::S_DONE: begin
        // result register free: hand over and take the next request now
        if (!stat.out_busy) begin
          cmd.result = 1'b1;
          in_stall   = 1'b0;
          cmd.load   = in_valid;
        end
      end
      default: cmd.op = tcce_pkg::OP_NONE;
    endcase
  end

endmodule

// ----- rtl/tcce_datapath.sv -----
// tcce_datapath: cursor, line counter, screen and line memories, sweep
// counter and result register. Uses tcce_pkg; commanded by tcce_ctrl.
module tcce_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tcce_pkg::cmd_t                 cmd,
  output tcce_pkg::stat_t                stat,
  input  logic [tcce_pkg::ATTR_W-1:0]    attr,
  input  logic [tcce_pkg::REQ_W-1:0]     in_req_type,
  input  logic [tcce_pkg::CHAR_W-1:0]    in_char_code,
  input  logic [tcce_pkg::CELL_W-1:0]    in_cell_index,
  input  logic [tcce_pkg::LIDX_W-1:0]    in_line_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tcce_pkg::CELL_W-1:0]    out_cursor_pos,
  output logic [tcce_pkg::ROW_W-1:0]     out_cursor_row,
  output logic [tcce_pkg::COL_W-1:0]     out_cursor_col,
  output logic [tcce_pkg::LINE_W-1:0]    out_line_length,
  output logic                           out_line_done,
  output logic                           out_accepted,
  output logic                           out_scrolled,
  output logic [tcce_pkg::DATA_W-1:0]    out_read_data
);

  // request registers
  tcce_pkg::req_t                 req_r;
  logic [tcce_pkg::CHAR_W-1:0]    ch_r;
  logic [tcce_pkg::CELL_W-1:0]    cell_r;
  logic [tcce_pkg::LIDX_W-1:0]    lidx_r;

  // architectural state
  logic [tcce_pkg::ROW_W-1:0]     row_r, row_nxt;
  logic [tcce_pkg::COL_W-1:0]     col_r, col_nxt;
  logic [tcce_pkg::LINE_W-1:0]    count_r, count_nxt;
  logic [tcce_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;

  // per-request flags
  logic                           done_r, done_nxt;
  logic                           acc_r, acc_nxt;
  logic                           scr_r, scr_nxt;
  logic [tcce_pkg::LINE_W-1:0]    nl_len_r, nl_len_nxt;
  tcce_pkg::rd_sel_t              rd_sel_r, rd_sel_nxt;

  // memories
  logic [tcce_pkg::DATA_W-1:0]    scr_mem [tcce_pkg::CELLS];
  logic [tcce_pkg::DATA_W-1:0]    scr_rdq;
  logic                           scr_we, scr_re;
  logic [tcce_pkg::CELL_W-1:0]    scr_wa, scr_ra;
  logic [tcce_pkg::DATA_W-1:0]    scr_wd;
  logic [tcce_pkg::CHAR_W-1:0]    line_mem [tcce_pkg::LINE_MAX];
  logic [tcce_pkg::CHAR_W-1:0]    line_rdq;
  logic                           line_we, line_re;

  logic                           out_valid_r;

  logic                           ch_nl, ch_bs, col_last, row_last, wrap;
  logic                           key_store, key_erase;
  logic [tcce_pkg::COL_W-1:0]     step_col, bs_col;
  logic [tcce_pkg::ROW_W-1:0]     step_row, bs_row;
  logic [tcce_pkg::CELL_W-1:0]    cur_pos, bs_pos;
  logic [tcce_pkg::DATA_W-1:0]    blank_cell;

  assign ch_nl      = (ch_r == tcce_pkg::CH_NEWLINE);
  assign ch_bs      = (ch_r == tcce_pkg::CH_BACKSPACE);
  assign col_last   = (col_r == tcce_pkg::COL_W'(tcce_pkg::COLS - 1));
  assign row_last   = (row_r == tcce_pkg::ROW_W'(tcce_pkg::ROWS - 1));
  assign blank_cell = {attr, tcce_pkg::CH_SPACE};
  assign key_store  = !ch_nl && !ch_bs &&
                      (count_r != tcce_pkg::LINE_W'(tcce_pkg::LINE_MAX - 1));
  assign key_erase  = ch_bs && (count_r != '0);

  // forward step; a printed newline also wraps. Last row holds (scroll or clamp).
  assign wrap     = col_last || ((cmd.op == tcce_pkg::OP_OUT) && ch_nl);
  assign step_col = wrap ? '0 : col_r + 1'b1;
  assign step_row = (wrap && !row_last) ? row_r + 1'b1 : row_r;

  assign bs_col = (col_r == '0) ? tcce_pkg::COL_W'(tcce_pkg::COLS - 1) : col_r - 1'b1;
  assign bs_row = ((col_r == '0) && (row_r != '0)) ? row_r - 1'b1 : row_r;

  assign cur_pos = tcce_pkg::pos_of(row_r, col_r);
  assign bs_pos  = tcce_pkg::pos_of(bs_row, bs_col);

  assign stat.req         = req_r;
  assign stat.scroll_need = (req_r == tcce_pkg::REQ_OUT) && (ch_nl || col_last) && row_last;
  assign stat.fill_last   = (cnt_r == tcce_pkg::CNT_W'(tcce_pkg::CELLS - 1));
  assign stat.copy_last   = (cnt_r == tcce_pkg::CNT_W'(tcce_pkg::CELLS));
  assign stat.out_busy    = out_valid_r && out_stall;

  always_comb begin
    row_nxt    = row_r;
    col_nxt    = col_r;
    count_nxt  = count_r;
    cnt_nxt    = cnt_r;
    done_nxt   = done_r;
    acc_nxt    = acc_r;
    scr_nxt    = scr_r;
    nl_len_nxt = nl_len_r;
    rd_sel_nxt = rd_sel_r;
    scr_we     = 1'b0;
    scr_wa     = cur_pos;
    scr_wd     = {attr, ch_r};
    scr_re     = 1'b0;
    scr_ra     = cell_r;
    line_we    = 1'b0;
    line_re    = 1'b0;
    unique case (cmd.op)
      tcce_pkg::OP_NONE: ;
      tcce_pkg::OP_OUT: begin
        scr_we  = !ch_nl;
        col_nxt = step_col;
        row_nxt = step_row;
        scr_nxt = stat.scroll_need;
      end
      tcce_pkg::OP_KEY: begin
        if (ch_nl) begin
          nl_len_nxt = count_r;
          count_nxt  = '0;
          done_nxt   = 1'b1;
        end else if (key_erase) begin
          count_nxt = count_r - 1'b1;
          col_nxt   = bs_col;
          row_nxt   = bs_row;
          scr_we    = 1'b1;
          scr_wa    = bs_pos;
          scr_wd    = blank_cell;
          acc_nxt   = 1'b1;
        end else if (key_store) begin
          line_we   = 1'b1;
          count_nxt = count_r + 1'b1;
          scr_we    = 1'b1;
          col_nxt   = step_col;
          row_nxt   = step_row;
          acc_nxt   = 1'b1;
        end
      end
      tcce_pkg::OP_READ: begin
        if (req_r == tcce_pkg::REQ_READ_CELL) begin
          if (cell_r < tcce_pkg::CELL_W'(tcce_pkg::CELLS)) begin
            scr_re     = 1'b1;
            rd_sel_nxt = tcce_pkg::RD_CELL;
          end
        end else begin
          line_re    = 1'b1;
          rd_sel_nxt = tcce_pkg::RD_LINE;
        end
      end
      tcce_pkg::OP_CLEAR: begin
        row_nxt = '0;
        col_nxt = '0;
      end
      tcce_pkg::OP_FILL: begin
        scr_we  = 1'b1;
        scr_wa  = tcce_pkg::CELL_W'(cnt_r);
        scr_wd  = blank_cell;
        cnt_nxt = cnt_r + 1'b1;
      end
      tcce_pkg::OP_INIT_FILL: begin
        scr_we  = 1'b1;
        scr_wa  = tcce_pkg::CELL_W'(cnt_r);
        scr_wd  = tcce_pkg::RESET_CELL;
        cnt_nxt = cnt_r + 1'b1;
      end
      tcce_pkg::OP_SCROLL: begin
        // read cell cnt+COLS, write it to cnt on the next sweep step; bottom row blanked
        scr_re  = (cnt_r < tcce_pkg::CNT_W'(tcce_pkg::COPY_CELLS));
        scr_ra  = tcce_pkg::CELL_W'(cnt_r + tcce_pkg::COLS);
        scr_we  = (cnt_r != '0);
        scr_wa  = tcce_pkg::CELL_W'(cnt_r - 1'b1);
        scr_wd  = (cnt_r <= tcce_pkg::CNT_W'(tcce_pkg::COPY_CELLS)) ? scr_rdq : blank_cell;
        cnt_nxt = cnt_r + 1'b1;
      end
    endcase
    if (cmd.load) begin
      cnt_nxt    = '0;
      done_nxt   = 1'b0;
      acc_nxt    = 1'b0;
      scr_nxt    = 1'b0;
      rd_sel_nxt = tcce_pkg::RD_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      count_r     <= '0;
      cnt_r       <= '0;
      done_r      <= 1'b0;
      acc_r       <= 1'b0;
      scr_r       <= 1'b0;
      rd_sel_r    <= tcce_pkg::RD_NONE;
      out_valid_r <= 1'b0;
    end else begin
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      count_r     <= count_nxt;
      cnt_r       <= cnt_nxt;
      done_r      <= done_nxt;
      acc_r       <= acc_nxt;
      scr_r       <= scr_nxt;
      rd_sel_r    <= rd_sel_nxt;
      out_valid_r <= cmd.result || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    nl_len_r <= nl_len_nxt;
    if (cmd.load) begin
      req_r  <= tcce_pkg::req_t'(in_req_type);
      ch_r   <= in_char_code;
      cell_r <= in_cell_index;
      lidx_r <= in_line_index;
    end
  end

  always_ff @(posedge clk) begin
    if (scr_we) scr_mem[scr_wa] <= scr_wd;
    if (scr_re) scr_rdq <= scr_mem[scr_ra];
  end

  always_ff @(posedge clk) begin
    if (line_we) line_mem[count_r] <= ch_r;
    if (line_re) line_rdq <= line_mem[lidx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.result) begin
      out_cursor_pos  <= cur_pos;
      out_cursor_row  <= row_r;
      out_cursor_col  <= col_r;
      out_line_length <= done_r ? nl_len_r : count_r;
      out_line_done   <= done_r;
      out_accepted    <= acc_r;
      out_scrolled    <= scr_r;
      unique case (rd_sel_r)
        tcce_pkg::RD_CELL: out_read_data <= scr_rdq;
        tcce_pkg::RD_LINE: out_read_data <= {{tcce_pkg::ATTR_W{1'b0}}, line_rdq};
        default:           out_read_data <= '0;
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/text_console_cursor_engine.sv -----
// text_console_cursor_engine: top level, attribute register on the APB port,
// tcce_ctrl sequencer and tcce_datapath. Uses tcce_pkg.
//
//   channel   direction  handshake            payload
//   in_*      request    in_valid / in_stall   req_type, char_code, cell_index, line_index
//   out_*     result     out_valid / out_stall cursor, line state, flags, read_data
//   APB       config     psel/penable/pready   text_attribute at byte address 0
//
// Print, key, read and unused requests pass through an execute and a result step;
// back to back a new request is taken at each result step while out_stall stays low.
// Clear screen and a scrolling print add a sweep of the screen memory, which has
// one read and one write port and is swept one cell per cycle.
// After reset the screen memory is blanked with in_stall high.
// A result held by out_stall stalls the following request at its result step.
module text_console_cursor_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [tcce_pkg::REQ_W-1:0]     in_req_type,
  input  logic [tcce_pkg::CHAR_W-1:0]    in_char_code,
  input  logic [tcce_pkg::CELL_W-1:0]    in_cell_index,
  input  logic [tcce_pkg::LIDX_W-1:0]    in_line_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tcce_pkg::CELL_W-1:0]    out_cursor_pos,
  output logic [tcce_pkg::ROW_W-1:0]     out_cursor_row,
  output logic [tcce_pkg::COL_W-1:0]     out_cursor_col,
  output logic [tcce_pkg::LINE_W-1:0]    out_line_length,
  output logic                           out_line_done,
  output logic                           out_accepted,
  output logic                           out_scrolled,
  output logic [tcce_pkg::DATA_W-1:0]    out_read_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic [tcce_pkg::ATTR_W-1:0] attr_r;
  logic [tcce_pkg::ATTR_W-1:0] attr_nxt;
  tcce_pkg::cmd_t              cmd;
  tcce_pkg::stat_t             stat;

  assign pready = 1'b1;

  always_comb begin
    attr_nxt = attr_r;
    if (psel && penable && pwrite && (paddr[2] == tcce_pkg::REG_ATTR)) begin
      attr_nxt = pwdata[tcce_pkg::ATTR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= tcce_pkg::ATTR_RESET;
    end else begin
      attr_r <= attr_nxt;
    end
  end

  assign prdata = (paddr[2] == tcce_pkg::REG_ATTR) ? {{(32 - tcce_pkg::ATTR_W){1'b0}}, attr_r}
                                                   : '0;

  tcce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcce_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .attr            (attr_r),
    .in_req_type     (in_req_type),
    .in_char_code    (in_char_code),
    .in_cell_index   (in_cell_index),
    .in_line_index   (in_line_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_cursor_pos  (out_cursor_pos),
    .out_cursor_row  (out_cursor_row),
    .out_cursor_col  (out_cursor_col),
    .out_line_length (out_line_length),
    .out_line_done   (out_line_done),
    .out_accepted    (out_accepted),
    .out_scrolled    (out_scrolled),
    .out_read_data   (out_read_data)
  );

endmodule

// ----- tb/text_console_cursor_engine_tb.sv -----
// text_console_cursor_engine_tb: self-checking bench for the text console engine.
// Sends print/key/clear/read requests and writes the attribute register over APB.
// Depends on tcce_pkg and the text_console_cursor_engine RTL.
module text_console_cursor_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [tcce_pkg::REQ_W-1:0] REQ_SPARE_LO = 3'd5;
  localparam logic [2:0]       ATTR_ADDR    = 3'({tcce_pkg::REG_ATTR, 2'b00});
  localparam int               CELL_SPAN    = 1 << tcce_pkg::CELL_W;

  typedef struct packed {
    logic [tcce_pkg::REQ_W-1:0]  kind;
    logic [tcce_pkg::CHAR_W-1:0] ch;
    logic [tcce_pkg::CELL_W-1:0] cidx;
    logic [tcce_pkg::LIDX_W-1:0] lidx;
  } console_req_t;

  typedef struct packed {
    logic [tcce_pkg::CELL_W-1:0] pos;
    logic [tcce_pkg::ROW_W-1:0]  row;
    logic [tcce_pkg::COL_W-1:0]  col;
    logic [tcce_pkg::LINE_W-1:0] len;
    logic                        done;
    logic                        acc;
    logic                        scr;
    logic [tcce_pkg::DATA_W-1:0] rd;
  } console_res_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [tcce_pkg::REQ_W-1:0]    in_req_type = '0;
  logic [tcce_pkg::CHAR_W-1:0]   in_char_code = '0;
  logic [tcce_pkg::CELL_W-1:0]   in_cell_index = '0;
  logic [tcce_pkg::LIDX_W-1:0]   in_line_index = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [tcce_pkg::CELL_W-1:0]   out_cursor_pos;
  logic [tcce_pkg::ROW_W-1:0]    out_cursor_row;
  logic [tcce_pkg::COL_W-1:0]    out_cursor_col;
  logic [tcce_pkg::LINE_W-1:0]   out_line_length;
  logic                          out_line_done;
  logic                          out_accepted;
  logic                          out_scrolled;
  logic [tcce_pkg::DATA_W-1:0]   out_read_data;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [2:0]                    paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  text_console_cursor_engine dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_req_type, .in_char_code, .in_cell_index, .in_line_index,
    .out_valid, .out_stall, .out_cursor_pos, .out_cursor_row, .out_cursor_col,
    .out_line_length, .out_line_done, .out_accepted, .out_scrolled, .out_read_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #2 clk = ~clk;

  // shadow of the console state
  logic [tcce_pkg::DATA_W-1:0] screen_shadow [tcce_pkg::CELLS];
  logic [tcce_pkg::CHAR_W-1:0] line_shadow [tcce_pkg::LINE_MAX];
  int                          cur_row, cur_col, typed_count;
  logic [tcce_pkg::ATTR_W-1:0] attr_shadow;

  console_req_t queued_requests[$];
  console_res_t due_results[$];
  int           fail_count = 0;

  // request-generation view of the typed line, so reads only touch written entries
  int gen_count = 0;
  int gen_line_hi = -1;
  int phase_items = 0;

  function automatic void put_cell(input int r, input int c,
                                   input logic [tcce_pkg::CHAR_W-1:0] ch);
    screen_shadow[r * tcce_pkg::COLS + c] = {attr_shadow, ch};
  endfunction

  // row advance; printed text scrolls, echoed keys clamp at the last row
  function automatic logic next_row(input bit may_scroll);
    cur_row++;
    if (cur_row < tcce_pkg::ROWS) return 1'b0;
    cur_row = tcce_pkg::ROWS - 1;
    if (!may_scroll) return 1'b0;
    for (int i = 0; i < tcce_pkg::CELLS - tcce_pkg::COLS; i++)
      screen_shadow[i] = screen_shadow[i + tcce_pkg::COLS];
    for (int c = 0; c < tcce_pkg::COLS; c++)
      put_cell(tcce_pkg::ROWS - 1, c, tcce_pkg::CH_SPACE);
    cur_col = 0;
    return 1'b1;
  endfunction

  function automatic console_res_t step_console(input console_req_t q);
    console_res_t res;
    int len_out;
    res = '0;
    len_out = typed_count;
    case (q.kind)
      tcce_pkg::REQ_OUT: begin
        if (q.ch == tcce_pkg::CH_NEWLINE) begin
          cur_col = 0;
          res.scr = next_row(1'b1);
        end else begin
          put_cell(cur_row, cur_col, q.ch);
          cur_col++;
          if (cur_col >= tcce_pkg::COLS) begin
            cur_col = 0;
            res.scr = next_row(1'b1);
          end
        end
      end
      tcce_pkg::REQ_KEY: begin
        if (q.ch == tcce_pkg::CH_NEWLINE) begin
          typed_count = 0;
          res.done = 1'b1;
        end else if (q.ch == tcce_pkg::CH_BACKSPACE) begin
          if (typed_count > 0) begin
            typed_count--;
            if (cur_col == 0) begin
              cur_col = tcce_pkg::COLS - 1;
              if (cur_row > 0) cur_row--;
            end else begin
              cur_col--;
            end
            put_cell(cur_row, cur_col, tcce_pkg::CH_SPACE);
            res.acc = 1'b1;
          end
        end else if (typed_count < tcce_pkg::LINE_MAX - 1) begin
          line_shadow[typed_count] = q.ch;
          typed_count++;
          put_cell(cur_row, cur_col, q.ch);
          cur_col++;
          if (cur_col >= tcce_pkg::COLS) begin
            cur_col = 0;
            void'(next_row(1'b0));
          end
          res.acc = 1'b1;
        end
        if (!res.done) len_out = typed_count;
      end
      tcce_pkg::REQ_CLEAR: begin
        for (int i = 0; i < tcce_pkg::CELLS; i++)
          screen_shadow[i] = {attr_shadow, tcce_pkg::CH_SPACE};
        cur_row = 0;
        cur_col = 0;
      end
      tcce_pkg::REQ_READ_CELL: begin
        if (q.cidx < tcce_pkg::CELLS) res.rd = screen_shadow[q.cidx];
      end
      tcce_pkg::REQ_READ_LINE: begin
        res.rd = tcce_pkg::DATA_W'(line_shadow[q.lidx]);
      end
      default: ;
    endcase
    res.len = tcce_pkg::LINE_W'(len_out);
    res.row = tcce_pkg::ROW_W'(cur_row);
    res.col = tcce_pkg::COL_W'(cur_col);
    res.pos = tcce_pkg::CELL_W'(cur_row * tcce_pkg::COLS + cur_col);
    return res;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("tb: %s", msg);
  endtask

  function automatic logic [tcce_pkg::CELL_W-1:0] pick_cell();
    if ($urandom_range(0, 9) == 0)
      return tcce_pkg::CELL_W'($urandom_range(tcce_pkg::CELLS, CELL_SPAN - 1));
    return tcce_pkg::CELL_W'($urandom_range(0, tcce_pkg::CELLS - 1));
  endfunction

  function automatic logic [tcce_pkg::LIDX_W-1:0] pick_line_index();
    if (gen_line_hi < 0) return tcce_pkg::LIDX_W'($urandom_range(0, 255));
    return tcce_pkg::LIDX_W'($urandom_range(0, gen_line_hi));
  endfunction

  task automatic queue_request(input logic [tcce_pkg::REQ_W-1:0] kind,
                               input logic [tcce_pkg::CHAR_W-1:0] ch,
                               input logic [tcce_pkg::CELL_W-1:0] cidx,
                               input logic [tcce_pkg::LIDX_W-1:0] lidx);
    if (kind == tcce_pkg::REQ_KEY) begin
      if (ch == tcce_pkg::CH_NEWLINE) begin
        gen_count = 0;
      end else if (ch == tcce_pkg::CH_BACKSPACE) begin
        if (gen_count > 0) gen_count--;
      end else if (gen_count < tcce_pkg::LINE_MAX - 1) begin
        if (gen_count > gen_line_hi) gen_line_hi = gen_count;
        gen_count++;
      end
    end
    phase_items++;
    queued_requests.push_back('{kind, ch, cidx, lidx});
  endtask

  task automatic queue_key(input logic [tcce_pkg::CHAR_W-1:0] ch);
    queue_request(tcce_pkg::REQ_KEY, ch, pick_cell(), pick_line_index());
  endtask

  task automatic queue_print(input logic [tcce_pkg::CHAR_W-1:0] ch);
    queue_request(tcce_pkg::REQ_OUT, ch, pick_cell(), pick_line_index());
  endtask

  task automatic queue_read();
    if ($urandom_range(0, 1) == 1 && gen_line_hi >= 0)
      queue_request(tcce_pkg::REQ_READ_LINE, tcce_pkg::CHAR_W'($urandom_range(0, 255)),
                    pick_cell(), pick_line_index());
    else
      queue_request(tcce_pkg::REQ_READ_CELL, tcce_pkg::CHAR_W'($urandom_range(0, 255)),
                    pick_cell(), pick_line_index());
  endtask

  task automatic queue_long_line();
    int n;
    n = $urandom_range(250, 262);
    repeat (n) queue_key(tcce_pkg::CHAR_W'($urandom_range(11, 255)));
    repeat ($urandom_range(0, 3)) queue_key(tcce_pkg::CH_BACKSPACE);
    queue_read();
    queue_key(tcce_pkg::CH_NEWLINE);
  endtask

  task automatic queue_random_sequence();
    int pick;
    logic [tcce_pkg::REQ_W-1:0] kind;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      // typed line with some corrections
      repeat ($urandom_range(0, 30)) begin
        if ($urandom_range(0, 99) < 15) queue_key(tcce_pkg::CH_BACKSPACE);
        else queue_key(tcce_pkg::CHAR_W'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 99) < 85) queue_key(tcce_pkg::CH_NEWLINE);
    end else if (pick < 65) begin
      repeat ($urandom_range(1, 30)) begin
        if ($urandom_range(0, 99) < 8) queue_print(tcce_pkg::CH_NEWLINE);
        else queue_print(tcce_pkg::CHAR_W'($urandom_range(0, 255)));
      end
    end else if (pick < 83) begin
      repeat ($urandom_range(1, 6)) queue_read();
    end else if (pick < 88) begin
      repeat ($urandom_range(1, 2))
        queue_request(REQ_SPARE_LO + tcce_pkg::REQ_W'($urandom_range(0, 2)),
                      tcce_pkg::CHAR_W'($urandom_range(0, 255)), pick_cell(),
                      tcce_pkg::LIDX_W'($urandom_range(0, 255)));
    end else if (pick < 91) begin
      queue_request(tcce_pkg::REQ_CLEAR, tcce_pkg::CHAR_W'($urandom_range(0, 255)),
                    pick_cell(), pick_line_index());
    end else if (pick < 93) begin
      queue_long_line();
    end else begin
      // noise: any request type with any content
      repeat ($urandom_range(1, 4)) begin
        kind = tcce_pkg::REQ_W'($urandom_range(0, 7));
        if (kind == tcce_pkg::REQ_READ_LINE && gen_line_hi < 0) kind = tcce_pkg::REQ_READ_CELL;
        queue_request(kind, tcce_pkg::CHAR_W'($urandom_range(0, 255)), pick_cell(),
                      pick_line_index());
      end
    end
  endtask

  task automatic wait_until_drained();
    while (queued_requests.size() != 0 || due_results.size() != 0 || in_valid)
      @(negedge clk);
  endtask

  task automatic write_attr(input logic [tcce_pkg::ATTR_W-1:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ATTR_ADDR;
    pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    attr_shadow = v;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata !== 32'(v))
      note_failure($sformatf("attribute readback %h, wrote %h", prdata, v));
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // request driver: bursts of random length separated by random gaps
  console_req_t cur_req;
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) due_results.push_back(step_console(cur_req));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (queued_requests.size() != 0) begin
          cur_req = queued_requests.pop_front();
          in_req_type <= cur_req.kind;
          in_char_code <= cur_req.ch;
          in_cell_index <= cur_req.cidx;
          in_line_index <= cur_req.lidx;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                       : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result-side stall, switching between patterns
  int stall_mode = 0;
  int stall_span = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_span == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_span = $urandom_range(20, 200);
      end else begin
        stall_span--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        2: out_stall <= ~out_stall;
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  console_res_t got_result;
  console_res_t want_result;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_result = {out_cursor_pos, out_cursor_row, out_cursor_col, out_line_length,
                    out_line_done, out_accepted, out_scrolled, out_read_data};
      if (due_results.size() == 0) begin
        note_failure($sformatf("unexpected result %p", got_result));
      end else begin
        want_result = due_results.pop_front();
        if (got_result !== want_result)
          note_failure($sformatf({"mismatch exp pos=%0d row=%0d col=%0d len=%0d done=%b ",
                                  "acc=%b scr=%b rd=%h / got pos=%0d row=%0d col=%0d ",
                                  "len=%0d done=%b acc=%b scr=%b rd=%h"},
                                 want_result.pos, want_result.row, want_result.col,
                                 want_result.len, want_result.done, want_result.acc,
                                 want_result.scr, want_result.rd,
                                 got_result.pos, got_result.row, got_result.col,
                                 got_result.len, got_result.done, got_result.acc,
                                 got_result.scr, got_result.rd));
      end
    end
  end

  initial begin
    for (int i = 0; i < tcce_pkg::CELLS; i++) screen_shadow[i] = tcce_pkg::RESET_CELL;
    for (int i = 0; i < tcce_pkg::LINE_MAX; i++) line_shadow[i] = '0;
    cur_row = 0;
    cur_col = 0;
    typed_count = 0;
    attr_shadow = tcce_pkg::ATTR_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, reset attribute
    queue_request(tcce_pkg::REQ_READ_CELL, 8'h00, 11'd0, 8'd0);
    queue_request(tcce_pkg::REQ_READ_CELL, 8'hFF, 11'(tcce_pkg::CELLS - 1), 8'd255);
    queue_request(tcce_pkg::REQ_READ_CELL, 8'h00, 11'(tcce_pkg::CELLS), 8'd0);
    queue_request(tcce_pkg::REQ_READ_CELL, 8'h00, 11'(CELL_SPAN - 1), 8'd0);
    queue_request(tcce_pkg::REQ_OUT, 8'h41, 11'd0, 8'd0);
    queue_request(tcce_pkg::REQ_OUT, 8'hFF, 11'd0, 8'd0);
    queue_request(tcce_pkg::REQ_OUT, 8'h00, 11'd0, 8'd0);
    queue_request(tcce_pkg::REQ_OUT, tcce_pkg::CH_BACKSPACE, 11'd0, 8'd0); // printed as a glyph
    queue_request(tcce_pkg::REQ_READ_CELL, 8'h00, 11'd3, 8'd0);
    queue_request(tcce_pkg::REQ_KEY, tcce_pkg::CH_BACKSPACE, 11'd0, 8'd0); // empty line, ignored
    queue_request(tcce_pkg::REQ_KEY, 8'h61, 11'd0, 8'd0);
    queue_request(tcce_pkg::REQ_KEY, 8'h62, 11'd0, 8'd0);
    queue_request(tcce_pkg::REQ_CLEAR, 8'h00, 11'd0, 8'd0);        // keeps the typed line
    queue_request(tcce_pkg::REQ_KEY, tcce_pkg::CH_BACKSPACE, 11'd0, 8'd0); // column 0 on row 0
    queue_request(tcce_pkg::REQ_OUT, tcce_pkg::CH_NEWLINE, 11'd0, 8'd0);
    queue_request(tcce_pkg::REQ_KEY, tcce_pkg::CH_BACKSPACE, 11'd0, 8'd0); // column 0 on row 1
    queue_request(tcce_pkg::REQ_READ_LINE, 8'h00, 11'd0, 8'd0);
    queue_request(tcce_pkg::REQ_READ_LINE, 8'h00, 11'd0, 8'd1);
    queue_request(tcce_pkg::REQ_KEY, 8'hFF, 11'd0, 8'd0);
    queue_request(tcce_pkg::REQ_KEY, 8'h00, 11'd0, 8'd0);
    queue_request(tcce_pkg::REQ_KEY, tcce_pkg::CH_NEWLINE, 11'd0, 8'd0);
    queue_request(REQ_SPARE_LO, 8'hFF, 11'(CELL_SPAN - 1), 8'd255);
    queue_request(REQ_SPARE_LO + 3'd1, 8'h00, 11'd0, 8'd0);
    queue_request(REQ_SPARE_LO + 3'd2, 8'h5A, 11'd1000, 8'd128);
    queue_request(tcce_pkg::REQ_READ_CELL, 8'h00, 11'(tcce_pkg::COLS - 1), 8'd0);
    wait_until_drained();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_attr(8'hFF);
        1: write_attr(8'h00);
        default: write_attr(tcce_pkg::ATTR_W'($urandom_range(0, 255)));
      endcase
      phase_items = 0;
      if (phase == 0) begin
        // full line typed on the last row: echo clamps, extra keys are dropped
        queue_request(tcce_pkg::REQ_CLEAR, 8'h00, pick_cell(), pick_line_index());
        repeat (tcce_pkg::ROWS - 1) queue_print(tcce_pkg::CH_NEWLINE);
        queue_long_line();
        queue_print(tcce_pkg::CH_NEWLINE);
      end
      while (phase_items < 170) queue_random_sequence();
      wait_until_drained();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
